FILE: rtl/core/pbgft_pkg.sv
// shared types and constants for the protobuf gear field tracker
package pbgft_pkg;

	// frame size bound for length-delimited fields that are skipped
	localparam int MAX_FRAME_BYTES = 4096;
	localparam int SKIP_W = $clog2(MAX_FRAME_BYTES + 1);

	localparam int FIELD_W = 16;
	localparam int GEAR_W = 6;
	localparam int BYTE_W = 8;
	localparam int VARINT_W = 64;
	localparam int VARINT_MAX_BYTES = 10;
	localparam int IDX_W = 4;
	localparam int SHAMT_W = 6;
	localparam int KEY_W = FIELD_W + 3;
	// low accumulator bits kept exactly, everything above folds into one sticky bit
	localparam int ACC_W = (KEY_W > SKIP_W) ? KEY_W : SKIP_W;
	localparam int CFG_W = FIELD_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [GEAR_W-1:0] MAX_GEAR_RST = GEAR_W'(24);
	localparam logic [FIELD_W-1:0] GEAR_FIELD_RST = FIELD_W'(21);
	localparam logic [FIELD_W-1:0] COUNT_FIELD_RST = FIELD_W'(24);

	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_I64 = 3'd1;
	localparam logic [2:0] WT_LEN = 3'd2;
	localparam logic [2:0] WT_I32 = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_GEAR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GEAR_FIELD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT_FIELD = 2'd2;

	typedef enum logic [1:0] {
		ACT_LIVE   = 2'd0,
		ACT_CFG    = 2'd1,
		ACT_FORGET = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_SHIFT     = 3'd0,
		ST_FIRST     = 3'd1,
		ST_IGNORED   = 3'd2,
		ST_GEAR_ERR  = 3'd3,
		ST_COUNT     = 3'd4,
		ST_COUNT_ERR = 3'd5
	} status_t;

	typedef struct packed {
		logic [GEAR_W-1:0]  max_gear;
		logic [FIELD_W-1:0] gear_field_id;
		logic [FIELD_W-1:0] count_field_id;
	} pbgft_cfg_t;

	// search outcome after the current byte
	typedef struct packed {
		logic              done;
		logic              failed;
		logic [GEAR_W-1:0] value;
	} pbgft_find_t;

endpackage

FILE: rtl/core/pbgft_parser.sv
// wire-format byte parser: varint keys, field skipping and target field search
module pbgft_parser
	import pbgft_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              clear,
	input  logic              is_cfg,
	input  logic [BYTE_W-1:0] frame_byte,
	input  pbgft_cfg_t        cfg,
	output pbgft_find_t       find
);

	typedef enum logic [1:0] {
		PH_KEY       = 2'd0,
		PH_VALUE     = 2'd1,
		PH_SKIPVAR   = 2'd2,
		PH_SKIPBYTES = 2'd3
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [ACC_W-1:0]   acc_lo_q, acc_lo_d;
	logic               acc_hi_q, acc_hi_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic [2:0]         kind_q, kind_d;
	logic [SKIP_W-1:0]  skip_q, skip_d;
	logic               done_q, done_d;
	logic               failed_q, failed_d;
	logic [GEAR_W-1:0]  value_q, value_d;

	logic [SHAMT_W-1:0]  shamt;
	logic [VARINT_W-1:0] contrib;
	logic [ACC_W-1:0]    cur_lo;
	logic                cur_hi;
	logic [FIELD_W-1:0]  target;
	logic                field_zero;
	logic                field_match;
	logic [2:0]          wk;
	logic [SKIP_W-1:0]   skip_dec;

	always_comb begin
		shamt = SHAMT_W'({2'b00, idx_q} * 6'd7);
		contrib = VARINT_W'(frame_byte[6:0]) << shamt;
		cur_lo = acc_lo_q | contrib[ACC_W-1:0];
		cur_hi = acc_hi_q | (|contrib[VARINT_W-1:ACC_W]);
		target = is_cfg ? cfg.count_field_id : cfg.gear_field_id;
		field_zero = !cur_hi && (cur_lo[ACC_W-1:3] == '0);
		field_match = !cur_hi && (cur_lo[ACC_W-1:3] == (ACC_W-3)'(target));
		wk = cur_lo[2:0];
		skip_dec = (skip_q != '0) ? skip_q - SKIP_W'(1) : skip_q;
	end

	always_comb begin
		phase_d = phase_q;
		acc_lo_d = acc_lo_q;
		acc_hi_d = acc_hi_q;
		idx_d = idx_q;
		kind_d = kind_q;
		skip_d = skip_q;
		done_d = done_q;
		failed_d = failed_q;
		value_d = value_q;
		if (!done_q) begin
			if (phase_q == PH_SKIPBYTES) begin
				skip_d = skip_dec;
				if (skip_dec == '0) begin
					phase_d = PH_KEY;
				end
			end else begin
				acc_lo_d = cur_lo;
				acc_hi_d = cur_hi;
				if (frame_byte[7]) begin
					idx_d = idx_q + IDX_W'(1);
					if (idx_d >= IDX_W'(VARINT_MAX_BYTES)) begin
						done_d = 1'b1;
						failed_d = 1'b1;
					end
				end else begin
					acc_lo_d = '0;
					acc_hi_d = 1'b0;
					idx_d = '0;
					unique case (phase_q)
						PH_KEY: begin
							if (field_zero) begin
								done_d = 1'b1;
								failed_d = 1'b1;
							end else begin
								kind_d = wk;
								if (field_match && wk == WT_VARINT) begin
									phase_d = PH_VALUE;
								end else if (wk == WT_VARINT || wk == WT_LEN) begin
									phase_d = PH_SKIPVAR;
								end else if (wk == WT_I64) begin
									phase_d = PH_SKIPBYTES;
									skip_d = SKIP_W'(8);
								end else if (wk == WT_I32) begin
									phase_d = PH_SKIPBYTES;
									skip_d = SKIP_W'(4);
								end else begin
									done_d = 1'b1;
									failed_d = 1'b1;
								end
							end
						end
						PH_VALUE: begin
							done_d = 1'b1;
							if (cur_hi || cur_lo == '0 || cur_lo > ACC_W'(cfg.max_gear)) begin
								failed_d = 1'b1;
							end else begin
								value_d = cur_lo[GEAR_W-1:0];
							end
						end
						default: begin
							// skipping a varint, or reading a length prefix
							if (kind_q == WT_LEN && (cur_hi || cur_lo != '0)) begin
								if (cur_hi || cur_lo > ACC_W'(MAX_FRAME_BYTES)) begin
									done_d = 1'b1;
									failed_d = 1'b1;
								end else begin
									skip_d = cur_lo[SKIP_W-1:0];
									phase_d = PH_SKIPBYTES;
								end
							end else begin
								phase_d = PH_KEY;
							end
						end
					endcase
				end
			end
		end
	end

	assign find.done = done_d;
	assign find.failed = failed_d;
	assign find.value = value_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY;
			acc_lo_q <= '0;
			acc_hi_q <= 1'b0;
			idx_q <= '0;
			kind_q <= '0;
			skip_q <= '0;
			done_q <= 1'b0;
			failed_q <= 1'b0;
			value_q <= '0;
		end else if (step) begin
			if (clear) begin
				phase_q <= PH_KEY;
				acc_lo_q <= '0;
				acc_hi_q <= 1'b0;
				idx_q <= '0;
				kind_q <= '0;
				skip_q <= '0;
				done_q <= 1'b0;
				failed_q <= 1'b0;
				value_q <= '0;
			end else begin
				phase_q <= phase_d;
				acc_lo_q <= acc_lo_d;
				acc_hi_q <= acc_hi_d;
				idx_q <= idx_d;
				kind_q <= kind_d;
				skip_q <= skip_d;
				done_q <= done_d;
				failed_q <= failed_d;
				value_q <= value_d;
			end
		end
	end

endmodule

FILE: rtl/core/protobuf_gear_field_tracker.sv
// Gear field tracker: scans protobuf wire-format frame bytes for the rear gear
// (live frames) or the gear count (config frames) and reports one status word
// on the last byte of each frame. One byte is taken every clock cycle unless
// the input side stalls; a byte passes an input register, combinational parsing
// logic and the result register. The input side stalls only while a finished
// report is held in the result register and the output side is not ready. The
// user must write configuration only while idle; the block does not enforce it.
module protobuf_gear_field_tracker
	import pbgft_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,  // frame_byte[7:0]
	input  logic [1:0]           s_tuser,  // action[1:0]
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata   // status[2:0], gear[8:3], shift_up[9],
	                                       // steps[15:10], gear_count[21:16], zero
);

	pbgft_cfg_t cfg_q;

	logic              valid_s1;
	action_t           action_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	logic              prior_valid_q;
	logic [GEAR_W-1:0] prior_gear_q;
	logic [GEAR_W-1:0] gear_total_q;

	logic              out_valid_q;
	logic [23:0]       out_data_q;

	logic              advance;
	logic              is_frame;
	logic              report;
	pbgft_find_t       find;
	logic              found;
	logic [GEAR_W-1:0] mag;

	status_t           status_c;
	logic [GEAR_W-1:0] gear_c;
	logic              up_c;
	logic [GEAR_W-1:0] steps_c;
	logic [GEAR_W-1:0] total_c;
	logic              prior_valid_c;
	logic [GEAR_W-1:0] prior_gear_c;

	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign is_frame = (action_s1 == ACT_LIVE) || (action_s1 == ACT_CFG);
	assign report = advance && is_frame && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_gear <= MAX_GEAR_RST;
			cfg_q.gear_field_id <= GEAR_FIELD_RST;
			cfg_q.count_field_id <= COUNT_FIELD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_GEAR: cfg_q.max_gear <= cfg_wdata[GEAR_W-1:0];
				CFG_GEAR_FIELD: cfg_q.gear_field_id <= cfg_wdata[FIELD_W-1:0];
				CFG_COUNT_FIELD: cfg_q.count_field_id <= cfg_wdata[FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= action_t'(s_tuser);
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	pbgft_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance && is_frame),
		.clear      (last_s1),
		.is_cfg     (action_s1 == ACT_CFG),
		.frame_byte (byte_s1),
		.cfg        (cfg_q),
		.find       (find)
	);

	assign found = find.done && !find.failed;
	assign mag = (find.value > prior_gear_q) ? find.value - prior_gear_q
	                                         : prior_gear_q - find.value;

	always_comb begin
		status_c = ST_IGNORED;
		gear_c = '0;
		up_c = 1'b0;
		steps_c = '0;
		total_c = gear_total_q;
		prior_valid_c = prior_valid_q;
		prior_gear_c = prior_gear_q;
		if (action_s1 == ACT_CFG) begin
			if (found) begin
				total_c = find.value;
				status_c = ST_COUNT;
			end else begin
				status_c = ST_COUNT_ERR;
			end
		end else if (!found) begin
			status_c = ST_GEAR_ERR;
		end else begin
			gear_c = find.value;
			if (!prior_valid_q) begin
				prior_gear_c = find.value;
				prior_valid_c = 1'b1;
				status_c = ST_FIRST;
			end else if (mag == '0 || mag > gear_total_q) begin
				status_c = ST_IGNORED;
			end else begin
				status_c = ST_SHIFT;
				up_c = find.value < prior_gear_q;
				steps_c = mag;
				prior_gear_c = find.value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_valid_q <= 1'b0;
			prior_gear_q <= '0;
			gear_total_q <= MAX_GEAR_RST;
		end else if (advance && action_s1 == ACT_FORGET) begin
			prior_valid_q <= 1'b0;
		end else if (report) begin
			prior_valid_q <= prior_valid_c;
			prior_gear_q <= prior_gear_c;
			gear_total_q <= total_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (report) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (report) begin
			out_data_q <= {2'b00, total_c, steps_c, up_c, gear_c, status_c};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	// a reported shift always moves by at least one gear and no more than the total
	a_shift_steps: assert property (@(posedge clk) disable iff (!arst_n)
		report && status_c == ST_SHIFT |-> steps_c != '0 && steps_c <= gear_total_q)
		else $error("shift with out of range step count");

	// a forget transaction leaves no prior gear behind
	a_forget: assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 == ACT_FORGET |=> !prior_valid_q)
		else $error("prior gear survived a forget transaction");

	// a held report is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |-> !report)
		else $error("report overwrote a pending result");

	// the parser starts every frame clean
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		report |=> !u_parser.done_q)
		else $error("parser state not cleared after frame end");

endmodule
